[hw/rtl/sct_pkg.sv]
// sct_pkg: shared types and constants for the sparse coordinate table.
// Used by sct_cell and sparse_coordinate_table; depends on nothing.
package sct_pkg;

	localparam int unsigned IDX_W = 16;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CNT_W = 7;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] new_val;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_val;
		logic                    status;
		logic [CNT_W-1:0]        entry_count;
	} out_item_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic capture;
		logic ins;
		logic del;
		logic wr;
	} cell_ctl_t;

endpackage

[hw/rtl/sparse_coordinate_table.sv]
// sparse_coordinate_table: sorted coordinate list of a sparse integer matrix,
// held in a chain of sct_cell entries. Depends on sct_pkg and sct_cell.
//
// Each item passes a compare state and then an update state: in the transfer cycle every cell compares its
// key with the incoming (row, col) and registers the result; in the update state
// the chain shifts right to insert, shifts left to remove, or writes the
// matching cell, and the result is loaded into the output register. The update
// state waits while the output register still holds an untaken result.
// The next input is taken as soon as the chain is back in its compare state.
// No clearing pass is needed after reset.
module sparse_coordinate_table #(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned INDEX_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sct_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output sct_pkg::out_item_t  out_item
);

	localparam int unsigned KW = (INDEX_BITS < sct_pkg::IDX_W) ? INDEX_BITS : sct_pkg::IDX_W;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_CMP = 2'b01,
		ST_UPD = 2'b10
	} state_t;

	state_t                             state_q;
	logic                               cmd_q;
	logic [KW-1:0]                      row_q;
	logic [KW-1:0]                      col_q;
	logic signed [sct_pkg::VAL_W-1:0]   val_q;
	logic [CW-1:0]                      cnt_q;
	logic                               out_valid_q;
	sct_pkg::out_item_t                 out_item_q;

	sct_pkg::cell_ctl_t                 ctl;
	logic [KW-1:0]                      key_row;
	logic [KW-1:0]                      key_col;
	logic                               accept;
	logic                               apply;
	logic                               hit;
	logic                               full;
	logic                               nonzero;
	logic signed [sct_pkg::VAL_W-1:0]   rd_val;
	logic [CW+sct_pkg::CNT_W-1:0]       cnt_ext;
	logic [CW-1:0]                      cnt_next;

	logic                               c_valid [CAPACITY];
	logic [KW-1:0]                      c_row   [CAPACITY];
	logic [KW-1:0]                      c_col   [CAPACITY];
	logic signed [sct_pkg::VAL_W-1:0]   c_val   [CAPACITY];
	logic                               c_ge    [CAPACITY];
	logic                               c_eq    [CAPACITY];
	logic signed [sct_pkg::VAL_W-1:0]   c_hv    [CAPACITY];
	logic [CAPACITY-1:0]                valid_vec;
	logic [CAPACITY-1:0]                eq_vec;

	assign in_ready = (state_q == ST_CMP);
	assign accept   = in_valid && in_ready;
	assign apply    = (state_q == ST_UPD) && (!out_valid_q || out_ready);

	assign key_row = in_ready ? in_item.row[KW-1:0] : row_q;
	assign key_col = in_ready ? in_item.col[KW-1:0] : col_q;

	assign hit     = |eq_vec;
	assign full    = (cnt_q == CW'(CAPACITY));
	assign nonzero = (val_q != '0);

	always_comb begin
		ctl.capture = accept;
		ctl.ins     = apply && cmd_q == sct_pkg::CMD_UPDATE && !hit && nonzero && !full;
		ctl.del     = apply && cmd_q == sct_pkg::CMD_UPDATE && hit && !nonzero;
		ctl.wr      = apply && cmd_q == sct_pkg::CMD_UPDATE && hit && nonzero;
	end

	always_comb begin
		rd_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_val = rd_val | c_hv[i];
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic                             lv;
			logic [KW-1:0]                    lr;
			logic [KW-1:0]                    lc;
			logic signed [sct_pkg::VAL_W-1:0] lval;
			logic                             lg;
			logic                             rv;
			logic [KW-1:0]                    rr;
			logic [KW-1:0]                    rc;
			logic signed [sct_pkg::VAL_W-1:0] rval;

			if (g == 0) begin : g_first
				assign lv   = 1'b0;
				assign lr   = '0;
				assign lc   = '0;
				assign lval = '0;
				assign lg   = 1'b0;
			end else begin : g_mid_l
				assign lv   = c_valid[g-1];
				assign lr   = c_row[g-1];
				assign lc   = c_col[g-1];
				assign lval = c_val[g-1];
				assign lg   = c_ge[g-1];
			end

			if (g == CAPACITY - 1) begin : g_last
				assign rv   = 1'b0;
				assign rr   = '0;
				assign rc   = '0;
				assign rval = '0;
			end else begin : g_mid_r
				assign rv   = c_valid[g+1];
				assign rr   = c_row[g+1];
				assign rc   = c_col[g+1];
				assign rval = c_val[g+1];
			end

			sct_cell #(
				.KW(KW)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.key_row (key_row),
				.key_col (key_col),
				.new_val (val_q),
				.l_valid (lv),
				.l_row   (lr),
				.l_col   (lc),
				.l_val   (lval),
				.l_ge    (lg),
				.r_valid (rv),
				.r_row   (rr),
				.r_col   (rc),
				.r_val   (rval),
				.valid   (c_valid[g]),
				.row     (c_row[g]),
				.col     (c_col[g]),
				.val     (c_val[g]),
				.ge      (c_ge[g]),
				.eq      (c_eq[g]),
				.hit_val (c_hv[g])
			);

			assign valid_vec[g] = c_valid[g];
			assign eq_vec[g]    = c_eq[g];
		end
	endgenerate

	always_comb begin
		cnt_next = cnt_q;
		if (ctl.ins) begin
			cnt_next = cnt_q + 1'b1;
		end else if (ctl.del) begin
			cnt_next = cnt_q - 1'b1;
		end
	end

	assign cnt_ext = {{sct_pkg::CNT_W{1'b0}}, cnt_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CMP;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			case (state_q)
				ST_CMP: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (apply) begin
						state_q <= ST_CMP;
					end
				end
				default: begin
					state_q <= ST_CMP;
				end
			endcase
			if (apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_item.cmd;
			row_q <= in_item.row[KW-1:0];
			col_q <= in_item.col[KW-1:0];
			val_q <= in_item.new_val;
		end
		if (apply) begin
			out_item_q.read_val    <= (cmd_q == sct_pkg::CMD_READ) ? rd_val : '0;
			out_item_q.status      <= (cmd_q == sct_pkg::CMD_UPDATE && !hit && nonzero && full)
				? sct_pkg::STATUS_FULL : sct_pkg::STATUS_DONE;
			out_item_q.entry_count <= cnt_ext[sct_pkg::CNT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(cnt_q))
		else $error("occupied cells disagree with entry count");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> $onehot0(eq_vec))
		else $error("more than one cell matches the key");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		apply && ctl.ins |=> !full || $past(cnt_q) == CW'(CAPACITY - 1))
		else $error("insert into a full table");

endmodule

[hw/rtl/sct_cell.sv]
// sct_cell: one entry of the sorted chain; compares against the broadcast key
// and shifts toward either neighbor on insert or remove. Depends on sct_pkg.
module sct_cell #(
	parameter int unsigned KW = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sct_pkg::cell_ctl_t               ctl,
	input  logic [KW-1:0]                    key_row,
	input  logic [KW-1:0]                    key_col,
	input  logic signed [sct_pkg::VAL_W-1:0] new_val,
	input  logic                             l_valid,
	input  logic [KW-1:0]                    l_row,
	input  logic [KW-1:0]                    l_col,
	input  logic signed [sct_pkg::VAL_W-1:0] l_val,
	input  logic                             l_ge,
	input  logic                             r_valid,
	input  logic [KW-1:0]                    r_row,
	input  logic [KW-1:0]                    r_col,
	input  logic signed [sct_pkg::VAL_W-1:0] r_val,
	output logic                             valid,
	output logic [KW-1:0]                    row,
	output logic [KW-1:0]                    col,
	output logic signed [sct_pkg::VAL_W-1:0] val,
	output logic                             ge,
	output logic                             eq,
	output logic signed [sct_pkg::VAL_W-1:0] hit_val
);

	logic                             valid_q;
	logic [KW-1:0]                    row_q;
	logic [KW-1:0]                    col_q;
	logic signed [sct_pkg::VAL_W-1:0] val_q;
	logic                             ge_q;
	logic                             eq_q;
	logic signed [sct_pkg::VAL_W-1:0] hv_q;
	logic                             ge_c;
	logic                             eq_c;

	// empty cells sort after every key
	assign ge_c = !valid_q || (row_q > key_row) || (row_q == key_row && col_q >= key_col);
	assign eq_c = valid_q && row_q == key_row && col_q == key_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ge_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (ctl.capture) begin
				ge_q <= ge_c;
				eq_q <= eq_c;
			end
			if (ctl.ins) begin
				if (l_ge) begin
					valid_q <= l_valid;
				end else if (ge_q) begin
					valid_q <= 1'b1;
				end
			end else if (ctl.del && ge_q) begin
				valid_q <= r_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			hv_q <= eq_c ? val_q : '0;
		end
		if (ctl.ins) begin
			if (l_ge) begin
				row_q <= l_row;
				col_q <= l_col;
				val_q <= l_val;
			end else if (ge_q) begin
				row_q <= key_row;
				col_q <= key_col;
				val_q <= new_val;
			end
		end else if (ctl.del) begin
			if (ge_q) begin
				row_q <= r_row;
				col_q <= r_col;
				val_q <= r_val;
			end
		end else if (ctl.wr && eq_q) begin
			val_q <= new_val;
		end
	end

	assign valid   = valid_q;
	assign row     = row_q;
	assign col     = col_q;
	assign val     = val_q;
	assign ge      = ge_q;
	assign eq      = eq_q;
	assign hit_val = hv_q;

endmodule

[tb/testbench.sv]
// Testbench for sparse_coordinate_table: queued update/read commands, a
// shadow copy of the sorted coordinate list, and field-by-field result checks.
// Depends on sct_pkg and the sparse_coordinate_table RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int CAPACITY = 64;
	localparam int POOL = 72;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	sct_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	sct_pkg::out_item_t out_item;

	sparse_coordinate_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// shadow of the sorted coordinate list
	logic [sct_pkg::IDX_W-1:0] mat_row [CAPACITY];
	logic [sct_pkg::IDX_W-1:0] mat_col [CAPACITY];
	logic signed [sct_pkg::VAL_W-1:0] mat_val [CAPACITY];
	int mat_used = 0;

	sct_pkg::in_item_t pending_cmds [$];
	sct_pkg::out_item_t expected_results [$];
	sct_pkg::out_item_t want;

	logic [sct_pkg::IDX_W-1:0] pool_row [POOL];
	logic [sct_pkg::IDX_W-1:0] pool_col [POOL];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int hold_req = 0;
	int hold_ack;
	int hold_left;

	int items_queued = 0;
	int results_seen = 0;
	int errors = 0;
	int n_reads = 0;
	int n_updates = 0;
	int n_drops = 0;
	int peak_used = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

	function automatic sct_pkg::out_item_t table_apply(sct_pkg::in_item_t it);
		sct_pkg::out_item_t res;
		int pos;
		bit hit;
		res = '0;
		pos = 0;
		while (pos < mat_used && (mat_row[pos] < it.row ||
				(mat_row[pos] == it.row && mat_col[pos] < it.col)))
			pos++;
		hit = pos < mat_used && mat_row[pos] == it.row && mat_col[pos] == it.col;
		if (it.cmd == sct_pkg::CMD_READ) begin
			n_reads++;
			if (hit)
				res.read_val = mat_val[pos];
		end else begin
			n_updates++;
			if (hit && it.new_val != 0) begin
				mat_val[pos] = it.new_val;
			end else if (hit) begin
				for (int i = pos; i < mat_used - 1; i++) begin
					mat_row[i] = mat_row[i + 1];
					mat_col[i] = mat_col[i + 1];
					mat_val[i] = mat_val[i + 1];
				end
				mat_used--;
			end else if (it.new_val != 0) begin
				if (mat_used >= CAPACITY) begin
					res.status = sct_pkg::STATUS_FULL;
					n_drops++;
				end else begin
					for (int i = mat_used; i > pos; i--) begin
						mat_row[i] = mat_row[i - 1];
						mat_col[i] = mat_col[i - 1];
						mat_val[i] = mat_val[i - 1];
					end
					mat_row[pos] = it.row;
					mat_col[pos] = it.col;
					mat_val[pos] = it.new_val;
					mat_used++;
				end
			end
		end
		if (mat_used > peak_used)
			peak_used = mat_used;
		res.entry_count = mat_used[sct_pkg::CNT_W-1:0];
		return res;
	endfunction

	function automatic logic signed [sct_pkg::VAL_W-1:0] rand_value();
		logic signed [sct_pkg::VAL_W-1:0] v;
		case ($urandom_range(5))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = '1;
			3: v = $urandom_range(255, 1);
			4: v = 0 - $urandom_range(255, 1);
			default: v = $urandom;
		endcase
		if (v == 0)
			v = 1;
		return v;
	endfunction

	task automatic count_error(string msg);
		if (errors < 10)
			$display("MISMATCH: %s", msg);
		errors++;
	endtask

	task automatic queue_item(logic c, logic [sct_pkg::IDX_W-1:0] r,
			logic [sct_pkg::IDX_W-1:0] k, logic signed [sct_pkg::VAL_W-1:0] v);
		sct_pkg::in_item_t it;
		it.cmd = c;
		it.row = r;
		it.col = k;
		it.new_val = v;
		pending_cmds.push_back(it);
		items_queued++;
	endtask

	// mix of pool updates, removals, reads and fully random noise
	task automatic queue_mixed(int n, int unsigned zero_pct);
		int unsigned r;
		int k;
		logic [31:0] rnd;
		logic [31:0] rnd2;
		logic signed [sct_pkg::VAL_W-1:0] v;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			k = $urandom_range(POOL - 1);
			if (r < 10) begin
				rnd = $urandom;
				rnd2 = $urandom;
				v = $urandom;
				if (rnd2[17:16] == 2'b00)
					v = 0;
				queue_item(rnd[31], rnd[15:0], rnd2[15:0], v);
			end else if (r < 10 + zero_pct) begin
				queue_item(sct_pkg::CMD_UPDATE, pool_row[k], pool_col[k], 0);
			end else if (r < 65) begin
				queue_item(sct_pkg::CMD_UPDATE, pool_row[k], pool_col[k], rand_value());
			end else begin
				queue_item(sct_pkg::CMD_READ, pool_row[k], pool_col[k], rand_value());
			end
		end
	endtask

	task automatic wait_drained();
		while (results_seen != items_queued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else if (!in_valid || in_ready) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_item <= pending_cmds.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_ack <= 0;
			hold_left <= 0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= 300;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// monitor: predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_results.push_back(table_apply(in_item));
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					count_error($sformatf("unexpected result val %0d status %0d count %0d",
						out_item.read_val, out_item.status, out_item.entry_count));
				end else begin
					want = expected_results.pop_front();
					if (out_item.read_val !== want.read_val)
						count_error($sformatf("read_val expected %0d got %0d",
							want.read_val, out_item.read_val));
					if (out_item.status !== want.status)
						count_error($sformatf("status expected %0d got %0d",
							want.status, out_item.status));
					if (out_item.entry_count !== want.entry_count)
						count_error($sformatf("entry_count expected %0d got %0d",
							want.entry_count, out_item.entry_count));
				end
			end
		end
	end

	initial begin
		logic [sct_pkg::IDX_W-1:0] base_rows [8];
		logic [31:0] rnd;
		int order [POOL];
		int j;
		int t;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// key pool: several keys share a row so column order matters
		base_rows[0] = '0;
		base_rows[1] = '1;
		for (int i = 2; i < 8; i++) begin
			rnd = $urandom;
			base_rows[i] = rnd[15:0];
		end
		for (int i = 0; i < POOL; i++) begin
			rnd = $urandom;
			pool_row[i] = base_rows[$urandom_range(7)];
			pool_col[i] = {rnd[8:0], i[6:0]};
		end

		// directed: empty table, corner keys and values, overwrite, removal
		queue_item(sct_pkg::CMD_READ, 16'h0000, 16'h0000, 0);
		queue_item(sct_pkg::CMD_UPDATE, 16'h0000, 16'h0000, 0);
		queue_item(sct_pkg::CMD_UPDATE, 16'h0000, 16'h0000, 32'h8000_0000);
		queue_item(sct_pkg::CMD_UPDATE, 16'hffff, 16'hffff, 32'h7fff_ffff);
		queue_item(sct_pkg::CMD_UPDATE, 16'h0000, 16'hffff, 32'hffff_ffff);
		queue_item(sct_pkg::CMD_UPDATE, 16'hffff, 16'h0000, 32'h0000_0001);
		queue_item(sct_pkg::CMD_UPDATE, 16'h5555, 16'haaaa, 32'h5555_5555);
		queue_item(sct_pkg::CMD_UPDATE, 16'haaaa, 16'h5555, 32'haaaa_aaaa);
		queue_item(sct_pkg::CMD_READ, 16'h0000, 16'h0000, 32'hffff_ffff);
		queue_item(sct_pkg::CMD_READ, 16'hffff, 16'hffff, 0);
		queue_item(sct_pkg::CMD_READ, 16'h0000, 16'hffff, 0);
		queue_item(sct_pkg::CMD_READ, 16'hffff, 16'h0000, 0);
		queue_item(sct_pkg::CMD_READ, 16'haaaa, 16'h5555, 0);
		queue_item(sct_pkg::CMD_READ, 16'h0000, 16'h0001, 0);
		queue_item(sct_pkg::CMD_UPDATE, 16'h0000, 16'h0000, 42);
		queue_item(sct_pkg::CMD_READ, 16'h0000, 16'h0000, 0);
		queue_item(sct_pkg::CMD_UPDATE, 16'hffff, 16'h0000, 0);
		queue_item(sct_pkg::CMD_READ, 16'hffff, 16'h0000, 0);
		queue_item(sct_pkg::CMD_UPDATE, 16'h0001, 16'h0001, 0);
		queue_item(sct_pkg::CMD_UPDATE, 16'h5555, 16'haaaa, 0);
		wait_drained();

		// fill past capacity in shuffled key order, with reads mixed in
		for (int i = 0; i < POOL; i++)
			order[i] = i;
		for (int i = POOL - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < POOL; i++) begin
			queue_item(sct_pkg::CMD_UPDATE, pool_row[order[i]], pool_col[order[i]],
				rand_value());
			if ($urandom_range(3) == 0) begin
				j = $urandom_range(POOL - 1);
				queue_item(sct_pkg::CMD_READ, pool_row[j], pool_col[j], rand_value());
			end
		end
		wait_drained();

		send_idle_pct = 84;
		recv_stall_pct = 0;
		queue_mixed(95, 15);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 84;
		queue_mixed(95, 45);
		wait_drained();

		send_idle_pct = 21;
		recv_stall_pct = 21;
		queue_mixed(95, 25);
		wait_drained();

		// back-pressure: receiver holds off while the sender keeps offering
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = hold_req + 1;
		queue_mixed(24, 20);
		wait_drained();

		if (expected_results.size() != 0)
			count_error($sformatf("%0d results never arrived", expected_results.size()));

		$display("run covered %0d updates and %0d reads; %0d inserts dropped when full",
			n_updates, n_reads, n_drops);
		$display("peak occupancy %0d of %0d entries, %0d failures", peak_used, CAPACITY,
			errors);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/sct_pkg.sv
hw/rtl/sct_cell.sv
hw/rtl/sparse_coordinate_table.sv
tb/testbench.sv
